### sv/bmma_pkg.sv
`timescale 1ns / 1ps

package bmma_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = 40;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = CFG_W'(8);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // control broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic bshift;   // b link shifts one cell toward cell 0
        logic bcap;     // b link captured into the column store
        logic mul_en;   // multiply a by the stored b element
        logic acc_en;   // add the product into the running sum
        logic sum_clr;  // start a new output row
        logic sshift;   // sums shift one cell toward cell 0
    } cell_ctl_t;

endpackage

### sv/bmma_ram.sv
`timescale 1ns / 1ps

module bmma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### sv/bmma_cell.sv
`timescale 1ns / 1ps

module bmma_cell #(
    parameter int MAX_N = 8,
    parameter int SUM_W = 35,
    parameter int KW    = 3
) (
    input  logic                                clk,
    input  bmma_pkg::cell_ctl_t                 ctl,
    input  logic [KW-1:0]                       k_idx,
    input  logic signed [bmma_pkg::ELEM_W-1:0]  a_in,
    input  logic signed [bmma_pkg::ELEM_W-1:0]  b_in,
    input  logic signed [SUM_W-1:0]             sum_in,
    output logic signed [bmma_pkg::ELEM_W-1:0]  b_out,
    output logic signed [SUM_W-1:0]             sum_out
);

    import bmma_pkg::*;

    logic signed [ELEM_W-1:0] b_link_reg;
    logic signed [ELEM_W-1:0] b_col_reg [MAX_N];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.bshift)
        begin
            b_link_reg <= b_in;
        end
        if (ctl.bcap)
        begin
            b_col_reg[k_idx] <= b_link_reg;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= a_in * b_col_reg[k_idx];
        end
        priority if (ctl.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
        else if (ctl.sshift)
        begin
            sum_reg <= sum_in;
        end
        else
        begin
            sum_reg <= sum_reg;
        end
    end

    assign b_out   = b_link_reg;
    assign sum_out = sum_reg;

endmodule

### sv/block_matrix_multiply_accumulate.sv
// block matrix multiply-accumulate, one row of MAX_N multiply cells
//
// input channel (item_valid / item_ready): each beat carries one element of
// block A and one of block B in row-major order, plus clear_acc and emit.
// item_ready is high only while the block is idle; a beat that does not end
// a block and carries no emit leaves the block idle, ready for the next beat.
// the beat that completes a block of n*n pairs starts the product: B is
// streamed column-wise into the cells, then each row of A is broadcast
// through the row while the cells multiply-accumulate and the row sums
// shift out toward cell 0 into the saturating accumulator. the A and B
// memories each have a single read port feeding the cell row.
// output channel (result_valid / result_ready): on emit, n*n accumulator
// entries go out row-major, last marks the final one; each passes through
// the read, capture and hold states and holds in the output register while
// the receiver stalls.
// cfg_wr_en / cfg_wr_data write block_size; the user writes it only while
// idle, and the block itself does not enforce it.
// reset: accumulator reads as zero, load count zero, block_size 8.
`timescale 1ns / 1ps

module block_matrix_multiply_accumulate #(
    parameter int MAX_N = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bmma_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic signed [bmma_pkg::ELEM_W-1:0]  a_value,
    input  logic signed [bmma_pkg::ELEM_W-1:0]  b_value,
    input  logic                                clear_acc,
    input  logic                                emit,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [bmma_pkg::ACC_W-1:0]   c_value,
    output logic                                last
);

    import bmma_pkg::*;

    localparam int ENTRIES = MAX_N * MAX_N;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW      = $clog2(ENTRIES + 1);
    localparam int NW      = $clog2(MAX_N + 1);
    localparam int KW      = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int SUM_W   = PROD_W + $clog2(MAX_N);

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD,
        S_B_TAIL,
        S_B_CAP,
        S_ROW_START,
        S_A_RD,
        S_A_DRAIN1,
        S_A_DRAIN2,
        S_SHIFT,
        S_WB_LAST,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_HOLD
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    block_size_reg;
    logic [CW-1:0]       load_count_reg;
    logic [ENTRIES-1:0]  acc_vld_reg;
    logic [NW-1:0]       i_reg;
    logic [NW-1:0]       j_reg;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       acc_addr_reg;
    logic                emit_pend_reg;
    logic                bshift_d_reg;
    logic                mul_d_reg;
    logic                acc_d_reg;
    logic                wb_pend_reg;
    logic                result_valid_reg;
    logic                last_reg;
    logic signed [ACC_W-1:0] c_value_reg;

    // datapath registers, no reset needed
    logic [KW-1:0]           k_d_reg;
    logic signed [SUM_W-1:0] wb_sum_reg;
    logic [AW-1:0]           wb_addr_reg;
    logic                    acc_vld_rd_reg;

    logic [NW-1:0]  n_eff;
    logic [NW-1:0]  n_m1;
    logic [CW-1:0]  total;
    logic [CW-1:0]  total_m1;
    logic [CW-1:0]  load_count_inc;
    logic           item_acc;

    logic [ELEM_W-1:0] a_rdata;
    logic [ELEM_W-1:0] b_rdata;
    logic [ACC_W-1:0]  acc_rdata;
    logic [ACC_W-1:0]  acc_wdata;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W:0]   acc_sum;

    cell_ctl_t     ctl;
    logic [KW-1:0] k_idx;

    logic signed [ELEM_W-1:0] b_link   [MAX_N];
    logic signed [ELEM_W-1:0] b_feed   [MAX_N];
    logic signed [SUM_W-1:0]  sum_link [MAX_N];
    logic signed [SUM_W-1:0]  sum_feed [MAX_N];

    // side length in use: zero acts as one, oversize clamps to MAX_N
    always_comb
    begin
        priority if (block_size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(block_size_reg) > MAX_N)
        begin
            n_eff = NW'(MAX_N);
        end
        else
        begin
            n_eff = NW'(block_size_reg);
        end
    end

    assign n_m1           = n_eff - NW'(1);
    assign total          = CW'(CW'(n_eff) * CW'(n_eff));
    assign total_m1       = total - CW'(1);
    assign load_count_inc = load_count_reg + CW'(1);

    assign item_ready = (state_reg == S_IDLE);
    assign item_acc   = item_valid && item_ready;

    // operand memories, written at the load slot, read in row-major sweeps
    bmma_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (ENTRIES)
    ) u_a_ram (
        .clk   (clk),
        .we    (item_acc),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (a_value),
        .raddr (addr_reg),
        .rdata (a_rdata)
    );

    bmma_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (ENTRIES)
    ) u_b_ram (
        .clk   (clk),
        .we    (item_acc),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (b_value),
        .raddr (addr_reg),
        .rdata (b_rdata)
    );

    // accumulator memory; entries not valid since reset or clear read as zero
    bmma_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ENTRIES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (wb_pend_reg),
        .waddr (wb_addr_reg),
        .wdata (acc_wdata),
        .raddr (acc_addr_reg),
        .rdata (acc_rdata)
    );

    // saturating add of a row sum into its accumulator entry
    always_comb
    begin
        acc_base = acc_vld_rd_reg ? $signed(acc_rdata) : '0;
        acc_sum  = (ACC_W+1)'(acc_base) + (ACC_W+1)'(wb_sum_reg);
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_wdata = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_wdata = acc_sum[ACC_W-1:0];
        end
    end

    // cell control
    assign ctl.bshift  = bshift_d_reg;
    assign ctl.bcap    = (state_reg == S_B_CAP);
    assign ctl.mul_en  = mul_d_reg;
    assign ctl.acc_en  = acc_d_reg;
    assign ctl.sum_clr = (state_reg == S_ROW_START);
    assign ctl.sshift  = (state_reg == S_SHIFT);
    assign k_idx       = (state_reg == S_B_CAP) ? i_reg[KW-1:0] : k_d_reg;

    // row of cells: b elements enter at cell n-1 and shift down so that
    // column c lands in cell c; row sums leave from cell 0
    for (genvar g = 0; g < MAX_N; g++)
    begin : g_cell
        if (g == MAX_N - 1)
        begin : g_end
            assign b_feed[g]   = $signed(b_rdata);
            assign sum_feed[g] = '0;
        end
        else
        begin : g_mid
            assign b_feed[g]   = (n_m1 == NW'(g)) ? $signed(b_rdata) : b_link[g+1];
            assign sum_feed[g] = sum_link[g+1];
        end

        bmma_cell #(
            .MAX_N (MAX_N),
            .SUM_W (SUM_W),
            .KW    (KW)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .k_idx   (k_idx),
            .a_in    ($signed(a_rdata)),
            .b_in    (b_feed[g]),
            .sum_in  (sum_feed[g]),
            .b_out   (b_link[g]),
            .sum_out (sum_link[g])
        );
    end

    always_ff @(posedge clk)
    begin
        k_d_reg        <= j_reg[KW-1:0];
        wb_sum_reg     <= sum_link[0];
        wb_addr_reg    <= acc_addr_reg;
        acc_vld_rd_reg <= acc_vld_reg[acc_addr_reg];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            block_size_reg   <= BLOCK_SIZE_RESET;
            load_count_reg   <= '0;
            acc_vld_reg      <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            addr_reg         <= '0;
            acc_addr_reg     <= '0;
            emit_pend_reg    <= 1'b0;
            bshift_d_reg     <= 1'b0;
            mul_d_reg        <= 1'b0;
            acc_d_reg        <= 1'b0;
            wb_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
            c_value_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                block_size_reg <= cfg_wr_data;
            end

            bshift_d_reg <= (state_reg == S_B_RD);
            mul_d_reg    <= (state_reg == S_A_RD);
            acc_d_reg    <= mul_d_reg;
            wb_pend_reg  <= (state_reg == S_SHIFT);

            if (wb_pend_reg)
            begin
                acc_vld_reg[wb_addr_reg] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (clear_acc)
                        begin
                            acc_vld_reg <= '0;
                        end
                        if (load_count_inc >= total)
                        begin
                            load_count_reg <= '0;
                            emit_pend_reg  <= emit;
                            addr_reg       <= '0;
                            i_reg          <= '0;
                            j_reg          <= '0;
                            state_reg      <= S_B_RD;
                        end
                        else
                        begin
                            load_count_reg <= load_count_inc;
                            if (emit)
                            begin
                                acc_addr_reg <= '0;
                                state_reg    <= S_EMIT_RD;
                            end
                        end
                    end
                end
                S_B_RD:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (j_reg == n_m1)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_B_TAIL;
                    end
                    else
                    begin
                        j_reg <= j_reg + NW'(1);
                    end
                end
                S_B_TAIL:
                begin
                    state_reg <= S_B_CAP;
                end
                S_B_CAP:
                begin
                    if (i_reg == n_m1)
                    begin
                        i_reg        <= '0;
                        addr_reg     <= '0;
                        acc_addr_reg <= '0;
                        state_reg    <= S_ROW_START;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_B_RD;
                    end
                end
                S_ROW_START:
                begin
                    j_reg     <= '0;
                    state_reg <= S_A_RD;
                end
                S_A_RD:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (j_reg == n_m1)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_A_DRAIN1;
                    end
                    else
                    begin
                        j_reg <= j_reg + NW'(1);
                    end
                end
                S_A_DRAIN1:
                begin
                    state_reg <= S_A_DRAIN2;
                end
                S_A_DRAIN2:
                begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    acc_addr_reg <= acc_addr_reg + AW'(1);
                    if (j_reg == n_m1)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_WB_LAST;
                    end
                    else
                    begin
                        j_reg <= j_reg + NW'(1);
                    end
                end
                S_WB_LAST:
                begin
                    if (i_reg == n_m1)
                    begin
                        i_reg <= '0;
                        if (emit_pend_reg)
                        begin
                            acc_addr_reg <= '0;
                            state_reg    <= S_EMIT_RD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + NW'(1);
                        state_reg <= S_ROW_START;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_CAP;
                end
                S_EMIT_CAP:
                begin
                    c_value_reg      <= acc_base;
                    last_reg         <= (CW'(acc_addr_reg) == total_m1);
                    result_valid_reg <= 1'b1;
                    state_reg        <= S_EMIT_HOLD;
                end
                S_EMIT_HOLD:
                begin
                    if (result_ready)
                    begin
                        result_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            acc_addr_reg <= acc_addr_reg + AW'(1);
                            state_reg    <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign c_value      = c_value_reg;
    assign last         = last_reg;

endmodule

### test/block_matrix_multiply_accumulate_tb.sv
`timescale 1ns / 1ps

module block_matrix_multiply_accumulate_tb;
    import bmma_pkg::*;

    localparam int     SIDE_MAX    = 8;
    localparam int     SLOTS       = SIDE_MAX * SIDE_MAX;
    // one full 8x8 product plus a 64-entry emit, with room to spare
    localparam int     DRAIN_GAP   = 600;
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam longint SAT_HI      = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint SAT_LO      = -(longint'(1) <<< (ACC_W - 1));

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // one expected accumulator entry on the result channel
    typedef struct packed {
        logic signed [ACC_W-1:0] c;
        logic                    tail;
    } c_beat_t;

    // mirrors the block: element stores, accumulator, load position and size
    class acc_block_tracker;
        logic signed [ELEM_W-1:0] a_mem [SLOTS];
        logic signed [ELEM_W-1:0] b_mem [SLOTS];
        longint                   acc   [SLOTS];
        int unsigned              fill;
        logic [CFG_W-1:0]         side_reg;
        c_beat_t                  c_due [$];
        int                       mismatches;
        int                       pairs_taken;
        int                       c_checked;

        function new();
            foreach (acc[i])
            begin
                a_mem[i] = '0;
                b_mem[i] = '0;
                acc[i]   = 0;
            end
            fill        = 0;
            side_reg    = BLOCK_SIZE_RESET;
            mismatches  = 0;
            pairs_taken = 0;
            c_checked   = 0;
        endfunction

        // 0 behaves as 1, anything above the array size as the array size
        function int unsigned side();
            int unsigned n;
            n = 32'(side_reg);
            if (n == 0)
                n = 1;
            if (n > SIDE_MAX)
                n = SIDE_MAX;
            return n;
        endfunction

        function void add_product(int unsigned n);
            longint      prod [SLOTS];
            longint      s;
            int unsigned r;
            int unsigned col;
            int unsigned k;
            for (r = 0; r < n; r++)
                for (col = 0; col < n; col++)
                begin
                    s = 0;
                    for (k = 0; k < n; k++)
                        s += longint'(a_mem[r * n + k]) * longint'(b_mem[k * n + col]);
                    prod[r * n + col] = s;
                end
            for (r = 0; r < n * n; r++)
            begin
                s = acc[r] + prod[r];
                if (s > SAT_HI)
                    s = SAT_HI;
                if (s < SAT_LO)
                    s = SAT_LO;
                acc[r] = s;
            end
        endfunction

        // clear, then load (and multiply when the block fills), then emit
        function void take_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                                logic clr, logic em);
            int unsigned n;
            int unsigned total;
            int unsigned slot;
            c_beat_t     beat;
            n     = side();
            total = n * n;
            if (clr)
                foreach (acc[i])
                    acc[i] = 0;
            slot = (fill >= SLOTS) ? SLOTS - 1 : fill;
            a_mem[slot] = a;
            b_mem[slot] = b;
            fill = (fill + 1) & 'h7F;
            if (fill >= total)
            begin
                add_product(n);
                fill = 0;
            end
            if (em)
                for (int unsigned i = 0; i < total; i++)
                begin
                    beat.c    = acc[i][ACC_W-1:0];
                    beat.tail = (i + 1 == total);
                    c_due.push_back(beat);
                end
            pairs_taken++;
        endfunction

        function void match_c(logic signed [ACC_W-1:0] c, logic tail);
            c_beat_t want;
            c_checked++;
            if (c_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat %0d with nothing due: c_value %0d last %0b",
                             c_checked, c, tail);
                return;
            end
            want = c_due.pop_front();
            if (want.c !== c || want.tail !== tail)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat %0d: c_value expected %0d got %0d, last expected %0b got %0b",
                             c_checked, want.c, c, want.tail, tail);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0]         cfg_wr_data  = '0;
    logic                     item_valid   = 1'b0;
    logic                     item_ready;
    logic signed [ELEM_W-1:0] a_value      = '0;
    logic signed [ELEM_W-1:0] b_value      = '0;
    logic                     clear_acc    = 1'b0;
    logic                     emit         = 1'b0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic signed [ACC_W-1:0]  c_value;
    logic                     last;

    // steady suspends the random idling on both channels
    bit                       steady       = 1'b0;
    longint                   cycles       = 0;
    int                       random_items = 0;

    acc_block_tracker tracker = new();

    block_matrix_multiply_accumulate #(
        .MAX_N(SIDE_MAX)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .a_value     (a_value),
        .b_value     (b_value),
        .clear_acc   (clear_acc),
        .emit        (emit),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .c_value     (c_value),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog, far above the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver is not ready with a probability of about 14 percent unless steady
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= 14);

    // every accepted result beat is checked against the oldest expectation
    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            tracker.match_c(c_value, last);

    // one input beat: optional idle cycles, then valid held until accepted.
    // valid stays high after the handshake so back-to-back beats never
    // lower and raise it in the same step
    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic clr, input logic em);
        while (!steady && $urandom_range(99) < 14)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        a_value    <= a;
        b_value    <= b;
        clear_acc  <= clr;
        emit       <= em;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        tracker.take_pair(a, b, clr, em);
    endtask

    // sender holds off until every due result is back, then lets any
    // product still in flight (one that emits nothing) finish
    task automatic drain_out();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.c_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // block_size is only written with the block idle
    task automatic set_side(input logic [CFG_W-1:0] v);
        drain_out();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.side_reg = v;
    endtask

    // mostly full-range values, with the two rails showing up often
    function automatic logic signed [ELEM_W-1:0] pick_elem();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12)
            return ELEM_MIN;
        if (r < 24)
            return ELEM_MAX;
        return ELEM_W'($urandom);
    endfunction

    // finish the open block: clear likely on its first beat, emit likely on
    // its last, with a few stray clears and emits in between
    task automatic run_block();
        int unsigned total;
        int unsigned first;
        total = tracker.side() * tracker.side();
        first = tracker.fill;
        if (first >= total)
            first = total - 1;
        for (int unsigned i = first; i < total; i++)
        begin
            send_pair(pick_elem(), pick_elem(),
                      (i == first && $urandom_range(99) < 40) || $urandom_range(99) < 3,
                      (i == total - 1 && $urandom_range(99) < 50) || $urandom_range(99) < 3);
            random_items++;
        end
    endtask

    initial
    begin
        int          side_plan [9];
        int unsigned total;
        int unsigned partial;
        int unsigned blocks;

        side_plan = '{15, 1, 3, 0, 5, 2, 4, 7, 6};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed beats ----
        // size and accumulator straight out of reset: a lone emit at size 8
        // gives 64 zeros
        send_pair(ELEM_MAX, ELEM_MIN, 1'b0, 1'b1);
        // shrink to 1 inside that block: the next beat lands in slot 1 and
        // completes the block from slot 0
        set_side(4'd1);
        send_pair(ELEM_MIN, ELEM_MIN, 1'b1, 1'b1);
        // rail products accumulated without clearing
        send_pair(ELEM_MIN, ELEM_MIN, 1'b0, 1'b1);
        send_pair(ELEM_MAX, ELEM_MAX, 1'b0, 1'b1);
        send_pair(ELEM_MIN, ELEM_MAX, 1'b0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1, 1'b1);
        // smallest nonzero steps, clear without emit then emit without clear
        send_pair(-16'sd1, 16'sd1, 1'b1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b0, 1'b1);
        // size 0 behaves as 1
        set_side(4'd0);
        send_pair(16'sh0100, ELEM_MIN, 1'b0, 1'b1);
        send_pair(ELEM_MAX, 16'sh0100, 1'b0, 1'b1);
        // size 15 behaves as 8: one beat with emit streams 64 entries
        set_side(4'd15);
        send_pair(16'sh7f00, -16'sh0080, 1'b0, 1'b1);
        // back to 1 with the 8x8 block open
        set_side(4'd1);
        send_pair(16'sh0201, ELEM_MAX, 1'b0, 1'b1);
        // size 9 also behaves as 8; open a block at slot 0
        set_side(4'd9);
        send_pair(ELEM_MAX, ELEM_MAX, 1'b1, 1'b1);
        // size 2 takes the open block over at slot 1; clear and emit on a
        // middle beat, then emit on the completing one
        set_side(4'd2);
        send_pair(ELEM_MIN, ELEM_MAX, 1'b1, 1'b1);
        send_pair(ELEM_MAX, ELEM_MIN, 1'b0, 1'b0);
        send_pair(ELEM_MIN, ELEM_MIN, 1'b0, 1'b1);
        // full 2x2 block of most-negative elements
        for (int i = 0; i < 4; i++)
            send_pair(ELEM_MIN, ELEM_MIN, i == 0, i == 3);

        // ---- random blocks ----
        // the first phase runs a full 8x8 block, so every store slot holds
        // data before any later size change inside a block
        foreach (side_plan[p])
        begin
            if (p > 0 && $urandom_range(1) == 1 && tracker.side() > 1)
            begin
                // abandon the current block part way and resize under it
                total   = tracker.side() * tracker.side();
                partial = $urandom_range(1, total - 1);
                for (int unsigned i = 0; i < partial; i++)
                begin
                    send_pair(pick_elem(), pick_elem(), $urandom_range(9) == 0,
                              $urandom_range(9) == 0);
                    random_items++;
                end
            end
            set_side(CFG_W'(side_plan[p]));
            // a long stretch with no idling on either side
            steady = (p == 2 || p == 3);
            total  = tracker.side() * tracker.side();
            blocks = (total >= 16) ? 1 : (16 + total - 1) / total;
            repeat (blocks) run_block();
        end
        steady = 1'b0;

        drain_out();

        $display("%0d input beats (%0d in random blocks), %0d results checked",
                 tracker.pairs_taken, random_items, tracker.c_checked);
        $display("sizes 0, 9 and 15 among those written, resizes inside open blocks, rail operands");
        if (tracker.mismatches == 0 && tracker.c_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
